### src/rplb_pkg.sv
`timescale 1ns / 1ps

package rplb_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int ID_W        = 64;
    localparam int RSSI_W      = 8;
    localparam int LEDN_W      = 4;
    localparam int CMP_W       = (CNT_W > LEDN_W) ? CNT_W : LEDN_W;
    localparam int MASK_W      = 8;
    localparam int MASK_N      = (MAX_ENTRIES < MASK_W) ? MAX_ENTRIES : MASK_W;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int PERIOD_W    = 7;
    localparam int TICK_W      = 16;
    localparam int SHIFT_W     = 7;
    localparam int RANGE_W     = 8;
    localparam int PROD_W      = 14;
    localparam int DIV_CNT_W   = $clog2(PROD_W);

    localparam logic [PERIOD_W-1:0] PERIOD_BASE = 7'd5;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX  = 7'd99;
    localparam logic [SHIFT_W-1:0]  PERIOD_SPAN = 7'd95;

    localparam logic signed [RSSI_W-1:0] RSSI_MIN_RST = -8'sd90;
    localparam logic signed [RSSI_W-1:0] RSSI_MAX_RST = -8'sd40;
    localparam logic [LEDN_W-1:0]        LEDN_RST     = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_RSSI_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RSSI_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD,
        OP_REPORT,
        OP_COMPLETE,
        OP_TICK
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_RD,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                seen;
        logic [PERIOD_W-1:0] period;
        logic [TICK_W-1:0]   count;
    } slot_t;

    localparam int SLOT_W = 1 + PERIOD_W + TICK_W;

    typedef struct packed {
        logic               start;
        logic [PROD_W-1:0]  dividend;
        logic [RANGE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quot;
    } div_rsp_t;

endpackage

### src/rssi_proximity_led_blinker.sv
`timescale 1ns / 1ps

// channel   handshake                   payload
// item      item_valid / item_ready     opcode, id_high, id_low, rssi_dbm
// result    result_valid / result_ready led_mask, accepted
// config    cfg_write (no handshake)    cfg_index, cfg_data
//
// Add device: no slot walk. Tick and scan complete: a walk over the registered slots,
// each slot costing one slot RAM read and one write-back. Scan report: the walk plus
// the bit-serial period division (one quotient bit a cycle over 14 bits).
// Reset clears all control state and the slot valid bits; no clearing pass.
// One transaction is worked at a time; a new one is taken while a result waits.
module rssi_proximity_led_blinker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_ready,
    input  logic [rplb_pkg::OP_W-1:0]               opcode,
    input  logic [rplb_pkg::ID_W-1:0]               id_high,
    input  logic [rplb_pkg::ID_W-1:0]               id_low,
    input  logic signed [rplb_pkg::RSSI_W-1:0]      rssi_dbm,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic [rplb_pkg::MASK_W-1:0]             led_mask,
    output logic                                    accepted,
    input  logic                                    cfg_write,
    input  logic [rplb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rplb_pkg::CFG_DATA_W-1:0]         cfg_data
);

    rplb_pkg::state_t                      state_reg;
    rplb_pkg::state_t                      state_next;

    rplb_pkg::opcode_t                     item_op_reg;
    logic [rplb_pkg::ID_W-1:0]             item_hi_reg;
    logic [rplb_pkg::ID_W-1:0]             item_lo_reg;
    logic signed [rplb_pkg::RSSI_W-1:0]    item_rssi_reg;

    logic signed [rplb_pkg::RSSI_W-1:0]    min_reg;
    logic signed [rplb_pkg::RSSI_W-1:0]    max_reg;
    logic [rplb_pkg::LEDN_W-1:0]           ledn_reg;

    logic [rplb_pkg::CNT_W-1:0]            dev_cnt_reg;
    logic [rplb_pkg::CNT_W-1:0]            dev_cnt_next;
    logic [rplb_pkg::IDX_W-1:0]            idx_reg;
    logic [rplb_pkg::IDX_W-1:0]            idx_next;
    logic [rplb_pkg::CNT_W-1:0]            idx_inc;
    logic [rplb_pkg::PERIOD_W-1:0]         period_reg;
    logic [rplb_pkg::PERIOD_W-1:0]         period_next;
    logic                                  acc_reg;
    logic                                  acc_next;
    logic [rplb_pkg::MAX_ENTRIES-1:0]      lamp_reg;
    logic [rplb_pkg::MAX_ENTRIES-1:0]      lamp_next;
    logic [rplb_pkg::MAX_ENTRIES-1:0]      slot_vld_reg;
    logic [rplb_pkg::MAX_ENTRIES-1:0]      slot_vld_next;

    logic                                  result_valid_reg;
    logic                                  result_valid_next;
    logic [rplb_pkg::MASK_W-1:0]           led_mask_reg;
    logic [rplb_pkg::MASK_W-1:0]           led_mask_next;
    logic                                  accepted_reg;
    logic                                  accepted_next;

    logic                                  id_we;
    logic [2*rplb_pkg::ID_W-1:0]           id_rdata;
    logic                                  slot_we;
    logic [rplb_pkg::SLOT_W-1:0]           slot_rdata;
    rplb_pkg::slot_t                       slot_cur;
    rplb_pkg::slot_t                       slot_new;
    logic [rplb_pkg::TICK_W-1:0]           cnt_inc;

    rplb_pkg::div_req_t                    div_req;
    rplb_pkg::div_rsp_t                    div_rsp;

    logic signed [rplb_pkg::RSSI_W:0]      range_s;
    logic signed [rplb_pkg::RSSI_W-1:0]    rssi_cl;
    logic [rplb_pkg::RSSI_W:0]             shifted;
    logic                                  rssi_ok;
    logic                                  room;
    rplb_pkg::state_t                      walk_first;

    rplb_ram #(
        .WIDTH (2 * rplb_pkg::ID_W),
        .DEPTH (rplb_pkg::MAX_ENTRIES)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (dev_cnt_reg[rplb_pkg::IDX_W-1:0]),
        .wdata ({item_hi_reg, item_lo_reg}),
        .raddr (idx_reg),
        .rdata (id_rdata)
    );

    rplb_ram #(
        .WIDTH (rplb_pkg::SLOT_W),
        .DEPTH (rplb_pkg::MAX_ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (idx_reg),
        .wdata (slot_new),
        .raddr (idx_reg),
        .rdata (slot_rdata)
    );

    rplb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // period arithmetic, all operands stay within nine signed bits
    assign range_s = {max_reg[rplb_pkg::RSSI_W-1], max_reg}
                   - {min_reg[rplb_pkg::RSSI_W-1], min_reg};
    assign rssi_cl = (item_rssi_reg > max_reg) ? max_reg : item_rssi_reg;
    assign shifted = {max_reg[rplb_pkg::RSSI_W-1], max_reg}
                   - {rssi_cl[rplb_pkg::RSSI_W-1], rssi_cl};
    assign rssi_ok = (item_rssi_reg > min_reg) && item_rssi_reg[rplb_pkg::RSSI_W-1];

    assign room = (dev_cnt_reg < rplb_pkg::CNT_W'(rplb_pkg::MAX_ENTRIES))
               && (rplb_pkg::CMP_W'(dev_cnt_reg) < rplb_pkg::CMP_W'(ledn_reg));

    assign walk_first = (dev_cnt_reg == '0) ? rplb_pkg::ST_DONE : rplb_pkg::ST_RD;
    assign idx_inc    = rplb_pkg::CNT_W'(idx_reg) + rplb_pkg::CNT_W'(1);

    // entries never written since reset read as zero
    assign slot_cur = slot_vld_reg[idx_reg] ? rplb_pkg::slot_t'(slot_rdata) : '0;
    assign cnt_inc  = slot_cur.count + 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        dev_cnt_next      = dev_cnt_reg;
        idx_next          = idx_reg;
        period_next       = period_reg;
        acc_next          = acc_reg;
        lamp_next         = lamp_reg;
        slot_vld_next     = slot_vld_reg;
        result_valid_next = result_valid_reg;
        led_mask_next     = led_mask_reg;
        accepted_next     = accepted_reg;
        id_we             = 1'b0;
        slot_we           = 1'b0;
        slot_new          = slot_cur;
        div_req.start     = 1'b0;
        div_req.dividend  = rplb_pkg::PROD_W'(shifted[rplb_pkg::SHIFT_W-1:0])
                          * rplb_pkg::PROD_W'(rplb_pkg::PERIOD_SPAN);
        div_req.divisor   = range_s[rplb_pkg::RANGE_W-1:0];

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            rplb_pkg::ST_IDLE:
            begin
                acc_next = 1'b0;
                if (item_valid)
                begin
                    state_next = rplb_pkg::ST_EXEC;
                end
            end
            rplb_pkg::ST_EXEC:
            begin
                idx_next = '0;
                case (item_op_reg)
                    rplb_pkg::OP_ADD:
                    begin
                        if (room)
                        begin
                            id_we        = 1'b1;
                            dev_cnt_next = dev_cnt_reg + 1'b1;
                            acc_next     = 1'b1;
                        end
                        state_next = rplb_pkg::ST_DONE;
                    end
                    rplb_pkg::OP_REPORT:
                    begin
                        if (!rssi_ok)
                        begin
                            state_next = rplb_pkg::ST_DONE;
                        end
                        else if (range_s <= 9'sd0)
                        begin
                            period_next = rplb_pkg::PERIOD_BASE;
                            state_next  = walk_first;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = rplb_pkg::ST_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = walk_first;
                    end
                endcase
            end
            rplb_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    period_next = rplb_pkg::PERIOD_W'(div_rsp.quot) + rplb_pkg::PERIOD_BASE;
                    state_next  = walk_first;
                end
            end
            rplb_pkg::ST_RD:
            begin
                state_next = rplb_pkg::ST_UPD;
            end
            rplb_pkg::ST_UPD:
            begin
                case (item_op_reg)
                    rplb_pkg::OP_REPORT:
                    begin
                        if (id_rdata == {item_hi_reg, item_lo_reg})
                        begin
                            slot_new.seen   = 1'b1;
                            slot_new.period = period_reg;
                        end
                    end
                    rplb_pkg::OP_COMPLETE:
                    begin
                        if (!slot_cur.seen)
                        begin
                            slot_new.period = '0;
                        end
                        slot_new.seen = 1'b0;
                    end
                    rplb_pkg::OP_TICK:
                    begin
                        if ((slot_cur.period != '0)
                            && (cnt_inc >= rplb_pkg::TICK_W'(slot_cur.period)))
                        begin
                            lamp_next[idx_reg] = ~lamp_reg[idx_reg];
                            slot_new.count     = '0;
                        end
                        else
                        begin
                            slot_new.count = cnt_inc;
                            if (slot_cur.period == '0)
                            begin
                                lamp_next[idx_reg] = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                slot_we                = 1'b1;
                slot_vld_next[idx_reg] = 1'b1;
                if (idx_inc == dev_cnt_reg)
                begin
                    state_next = rplb_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = idx_inc[rplb_pkg::IDX_W-1:0];
                    state_next = rplb_pkg::ST_RD;
                end
            end
            rplb_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    led_mask_next     = rplb_pkg::MASK_W'(lamp_reg[rplb_pkg::MASK_N-1:0]);
                    accepted_next     = acc_reg;
                    state_next        = rplb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rplb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rplb_pkg::ST_IDLE;
            dev_cnt_reg      <= '0;
            idx_reg          <= '0;
            acc_reg          <= 1'b0;
            lamp_reg         <= '0;
            slot_vld_reg     <= '0;
            result_valid_reg <= 1'b0;
            led_mask_reg     <= '0;
            accepted_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            dev_cnt_reg      <= dev_cnt_next;
            idx_reg          <= idx_next;
            acc_reg          <= acc_next;
            lamp_reg         <= lamp_next;
            slot_vld_reg     <= slot_vld_next;
            result_valid_reg <= result_valid_next;
            led_mask_reg     <= led_mask_next;
            accepted_reg     <= accepted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= rplb_pkg::RSSI_MIN_RST;
            max_reg  <= rplb_pkg::RSSI_MAX_RST;
            ledn_reg <= rplb_pkg::LEDN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rplb_pkg::REG_RSSI_MIN:  min_reg  <= cfg_data;
                rplb_pkg::REG_RSSI_MAX:  max_reg  <= cfg_data;
                rplb_pkg::REG_LED_COUNT: ledn_reg <= cfg_data[rplb_pkg::LEDN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_op_reg   <= rplb_pkg::opcode_t'(opcode);
            item_hi_reg   <= id_high;
            item_lo_reg   <= id_low;
            item_rssi_reg <= rssi_dbm;
        end
        period_reg <= period_next;
    end

    assign item_ready   = (state_reg == rplb_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign led_mask     = led_mask_reg;
    assign accepted     = accepted_reg;

    a_dev_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dev_cnt_reg <= rplb_pkg::CNT_W'(rplb_pkg::MAX_ENTRIES))
        else $error("device count above table depth");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rplb_pkg::ST_UPD) |-> (rplb_pkg::CNT_W'(idx_reg) < dev_cnt_reg))
        else $error("slot walk beyond registered devices");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        id_we |=> (dev_cnt_reg == $past(dev_cnt_reg) + rplb_pkg::CNT_W'(1)))
        else $error("identifier write without device count advance");

    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |-> ((slot_new.period == '0)
            || ((slot_new.period >= rplb_pkg::PERIOD_BASE)
                && (slot_new.period <= rplb_pkg::PERIOD_MAX))))
        else $error("blink period out of range");

endmodule

### src/rplb_ram.sv
`timescale 1ns / 1ps

module rplb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/rplb_div.sv
`timescale 1ns / 1ps

module rplb_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rplb_pkg::div_req_t req,
    output rplb_pkg::div_rsp_t rsp
);

    localparam logic [rplb_pkg::DIV_CNT_W-1:0] DIV_LAST =
        rplb_pkg::DIV_CNT_W'(rplb_pkg::PROD_W - 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [rplb_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [rplb_pkg::RANGE_W-1:0]     rem_reg;
    logic [rplb_pkg::RANGE_W-1:0]     rem_next;
    logic [rplb_pkg::PROD_W-1:0]      quo_reg;
    logic [rplb_pkg::PROD_W-1:0]      quo_next;
    logic [rplb_pkg::RANGE_W-1:0]     dsr_reg;
    logic [rplb_pkg::RANGE_W:0]       trial;
    logic [rplb_pkg::RANGE_W:0]       diff;
    logic                             fits;

    // one quotient bit per cycle, dividend shifts out as quotient shifts in
    assign trial = {rem_reg, quo_reg[rplb_pkg::PROD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        rem_next = fits ? diff[rplb_pkg::RANGE_W-1:0] : trial[rplb_pkg::RANGE_W-1:0];
        quo_next = {quo_reg[rplb_pkg::PROD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_LAST;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule
